// ----- rtl/ucer_pkg.sv -----
`default_nettype none
package ucer_pkg;

  // input beat codes
  localparam logic [2:0] OP_BUS_RESET = 3'd0;
  localparam logic [2:0] OP_WAKEUP    = 3'd1;
  localparam logic [2:0] OP_SUSPEND   = 3'd2;
  localparam logic [2:0] OP_SETUP     = 3'd3;
  localparam logic [2:0] OP_OUT_BYTE  = 3'd4;
  localparam logic [2:0] OP_IN_TOKEN  = 3'd5;
  localparam logic [2:0] OP_OUT_EMPTY = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_ZLP     = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // transfer phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_IN      = 3'd1;
  localparam logic [2:0] PH_ADDR    = 3'd2;
  localparam logic [2:0] PH_OUT     = 3'd4;

  // data sources
  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_DEV  = 3'd1;
  localparam logic [2:0] SRC_CFG  = 3'd2;
  localparam logic [2:0] SRC_LANG = 3'd3;
  localparam logic [2:0] SRC_MANU = 3'd4;
  localparam logic [2:0] SRC_PROD = 3'd5;
  localparam logic [2:0] SRC_LINE = 3'd6;
  localparam logic [2:0] SRC_LUN  = 3'd7;

  // requests
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
  localparam logic [7:0] REQ_GET_DESC      = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
  localparam logic [7:0] REQ_SET_LINE      = 8'h20;
  localparam logic [7:0] REQ_GET_LINE      = 8'h21;
  localparam logic [7:0] REQ_LINE_STATE    = 8'h22;
  localparam logic [7:0] REQ_STORAGE_RESET = 8'hFF;
  localparam logic [7:0] REQ_GET_MAX_LUN   = 8'hFE;

  // register indexes
  localparam logic [1:0] REG_MAX_LUN   = 2'd0;
  localparam logic [1:0] REG_BULK_PKT  = 2'd1;
  localparam logic [1:0] REG_INT_IVAL  = 2'd2;

  localparam int CFG_LEN = 106;

  typedef struct packed {
    logic       start;
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic       busy;
  } stat_t;

  function automatic logic [7:0] dev_byte(input logic [6:0] i);
    logic [7:0] r;
    case (i)
      7'd0: r = 8'h12;  7'd1: r = 8'h01;  7'd2: r = 8'h00;  7'd3: r = 8'h02;
      7'd4: r = 8'hEF;  7'd5: r = 8'h02;  7'd6: r = 8'h01;  7'd7: r = 8'h00;
      7'd8: r = 8'h40;  7'd9: r = 8'h1c;  7'd10: r = 8'h38; 7'd11: r = 8'h05;
      7'd12: r = 8'h01; 7'd13: r = 8'h00; 7'd14: r = 8'h01; 7'd15: r = 8'h02;
      7'd16: r = 8'h00; 7'd17: r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cfg_byte(input logic [6:0] i);
    logic [7:0] r;
    case (i)
      7'd0: r = 8'h09; 7'd1: r = 8'h02; 7'd2: r = 8'h6A; 7'd3: r = 8'h00;
      7'd4: r = 8'h03; 7'd5: r = 8'h01; 7'd6: r = 8'h00; 7'd7: r = 8'h80;
      7'd8: r = 8'd200;
      7'd9: r = 8'h08; 7'd10: r = 8'h0B; 7'd11: r = 8'h00; 7'd12: r = 8'h02;
      7'd13: r = 8'h02; 7'd14: r = 8'h02; 7'd15: r = 8'h00; 7'd16: r = 8'h00;
      7'd17: r = 8'h09; 7'd18: r = 8'h04; 7'd19: r = 8'h00; 7'd20: r = 8'h00;
      7'd21: r = 8'h01; 7'd22: r = 8'h02; 7'd23: r = 8'h02; 7'd24: r = 8'h00;
      7'd25: r = 8'h00;
      7'd26: r = 8'h05; 7'd27: r = 8'h24; 7'd28: r = 8'h00; 7'd29: r = 8'h10;
      7'd30: r = 8'h01;
      7'd31: r = 8'h04; 7'd32: r = 8'h24; 7'd33: r = 8'h02; 7'd34: r = 8'h00;
      7'd35: r = 8'h05; 7'd36: r = 8'h24; 7'd37: r = 8'h06; 7'd38: r = 8'h00;
      7'd39: r = 8'h01;
      7'd40: r = 8'h05; 7'd41: r = 8'h24; 7'd42: r = 8'h01; 7'd43: r = 8'h00;
      7'd44: r = 8'h01;
      7'd45: r = 8'h07; 7'd46: r = 8'h05; 7'd47: r = 8'h83; 7'd48: r = 8'h03;
      7'd49: r = 8'h08; 7'd50: r = 8'h00; 7'd51: r = 8'h00;
      7'd52: r = 8'h09; 7'd53: r = 8'h04; 7'd54: r = 8'h01; 7'd55: r = 8'h00;
      7'd56: r = 8'h02; 7'd57: r = 8'h0A; 7'd58: r = 8'h00; 7'd59: r = 8'h00;
      7'd60: r = 8'h06;
      7'd61: r = 8'h07; 7'd62: r = 8'h05; 7'd63: r = 8'h81; 7'd64: r = 8'h02;
      7'd65: r = 8'h00; 7'd66: r = 8'h00; 7'd67: r = 8'h00;
      7'd68: r = 8'h07; 7'd69: r = 8'h05; 7'd70: r = 8'h02; 7'd71: r = 8'h02;
      7'd72: r = 8'h00; 7'd73: r = 8'h00; 7'd74: r = 8'h00;
      7'd75: r = 8'h08; 7'd76: r = 8'h0B; 7'd77: r = 8'h02; 7'd78: r = 8'h01;
      7'd79: r = 8'h08; 7'd80: r = 8'h06; 7'd81: r = 8'h50; 7'd82: r = 8'h00;
      7'd83: r = 8'h09; 7'd84: r = 8'h04; 7'd85: r = 8'h02; 7'd86: r = 8'h00;
      7'd87: r = 8'h02; 7'd88: r = 8'h08; 7'd89: r = 8'h06; 7'd90: r = 8'h50;
      7'd91: r = 8'h00;
      7'd92: r = 8'h07; 7'd93: r = 8'h05; 7'd94: r = 8'h84; 7'd95: r = 8'h02;
      7'd96: r = 8'h00; 7'd97: r = 8'h00; 7'd98: r = 8'h00;
      7'd99: r = 8'h07; 7'd100: r = 8'h05; 7'd101: r = 8'h05; 7'd102: r = 8'h02;
      7'd103: r = 8'h00; 7'd104: r = 8'h00; 7'd105: r = 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] manu_char(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = 8'h4D; 5'd1: r = 8'h61; 5'd2: r = 8'h6E; 5'd3: r = 8'h75;
      5'd4: r = 8'h46; 5'd5: r = 8'h65; 5'd6: r = 8'h72; 5'd7: r = 8'h48;
      5'd8: r = 8'h69; 5'd9: r = 8'h2F; 5'd10: r = 8'h53; 5'd11: r = 8'h6C;
      5'd12: r = 8'h69; 5'd13: r = 8'h6E; 5'd14: r = 8'h67; 5'd15: r = 8'h73;
      5'd16: r = 8'h68; 5'd17: r = 8'h6F; 5'd18: r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] prod_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h53; 3'd1: r = 8'h69; 3'd2: r = 8'h44; 3'd3: r = 8'h69;
      3'd4: r = 8'h31; 3'd5: r = 8'h32; 3'd6: r = 8'h38;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/usb_control_endpoint_responder.sv -----
`default_nettype none
// channel   | handshake               | payload
// in        | in_valid / in_ready     | op, setup_request, value_*, max_length, ...
// out       | out_valid / out_ready   | kind, data_byte, last, status flags
// cfg       | cfg_write               | cfg_index, cfg_data
//
// one beat is taken, then all of its results are sent before the next beat is taken
// an IN token with n packet bytes gives one data beat a cycle unless stalled, up to
// EP0_PACKET_BYTES beats, set by the single descriptor read port; the next beat is taken
// after the last is accepted; other beats give one result the cycle after they are taken
// rst is synchronous and resets all state, line coding back to 115200 8N1
// a stalled out beat holds the whole block
module usb_control_endpoint_responder #(
  parameter int EP0_PACKET_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [7:0]  setup_request,
  input  wire logic [7:0]  value_low,
  input  wire logic [7:0]  value_high,
  input  wire logic [15:0] max_length,
  input  wire logic        setup_complete,
  input  wire logic [7:0]  out_data,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic             last,
  output logic [6:0]       device_address,
  output logic             address_enabled,
  output logic             enumerated,
  output logic             tx_armed,
  output logic             rx_armed,
  output logic             suspended
);

  ucer_pkg::cmd_t  cmd;
  ucer_pkg::stat_t stat;

  // sequencer
  ucer_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .stat(stat), .cmd(cmd)
  );

  // state and descriptor datapath
  ucer_dp #(.EP0_PACKET_BYTES(EP0_PACKET_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .setup_request(setup_request), .value_low(value_low), .value_high(value_high),
    .max_length(max_length), .setup_complete(setup_complete), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .data_byte(data_byte), .last(last), .device_address(device_address),
    .address_enabled(address_enabled), .enumerated(enumerated),
    .tx_armed(tx_armed), .rx_armed(rx_armed), .suspended(suspended)
  );

endmodule
`default_nettype wire

// ----- rtl/ucer_ctrl.sv -----
`default_nettype none
// sequencer: waits for a beat, starts the datapath, then drains its results
module ucer_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          op,
  input  wire ucer_pkg::stat_t     stat,
  output ucer_pkg::cmd_t           cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_RUN;
      S_RUN:  if (!stat.busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign cmd.start = in_valid && (state == S_IDLE);
  assign cmd.op    = op;

endmodule
`default_nettype wire

// ----- rtl/ucer_dp.sv -----
`default_nettype none
// endpoint-zero state, descriptor reads and the result register
module ucer_dp #(
  parameter int EP0_PACKET_BYTES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ucer_pkg::cmd_t      cmd,
  output ucer_pkg::stat_t          stat,
  input  wire logic [7:0]          setup_request,
  input  wire logic [7:0]          value_low,
  input  wire logic [7:0]          value_high,
  input  wire logic [15:0]         max_length,
  input  wire logic                setup_complete,
  input  wire logic [7:0]          out_data,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [9:0]          cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               kind,
  output logic [7:0]               data_byte,
  output logic                     last,
  output logic [6:0]               device_address,
  output logic                     address_enabled,
  output logic                     enumerated,
  output logic                     tx_armed,
  output logic                     rx_armed,
  output logic                     suspended
);

  localparam logic [6:0] PKT = 7'(EP0_PACKET_BYTES);

  logic [3:0] max_lun;
  logic [9:0] bulk_pkt_len;
  logic [7:0] int_ival;

  logic [2:0] phase;
  logic [2:0] src;
  logic [6:0] offset;
  logic [6:0] remaining;
  logic [7:0] line_coding [7];
  logic [6:0] addr;
  logic       addr_on;
  logic       enum_flag;
  logic       susp;

  // burst counter for an IN packet
  logic       busy;
  logic [6:0] burst_left;

  // rom read
  logic [7:0] rom;
  logic [4:0] char_idx;
  always_comb begin
    rom = 8'h00;
    char_idx = 5'(offset[6:1] - 6'd1);
    case (src)
      ucer_pkg::SRC_DEV:
        rom = (offset == 7'd7) ? 8'(EP0_PACKET_BYTES) : ucer_pkg::dev_byte(offset);
      ucer_pkg::SRC_CFG: begin
        if (offset == 7'd51) rom = int_ival;
        else if (offset == 7'd65 || offset == 7'd72 || offset == 7'd96 || offset == 7'd103)
          rom = bulk_pkt_len[7:0];
        else if (offset == 7'd66 || offset == 7'd73 || offset == 7'd97 || offset == 7'd104)
          rom = {6'd0, bulk_pkt_len[9:8]};
        else rom = ucer_pkg::cfg_byte(offset);
      end
      ucer_pkg::SRC_LANG:
        case (offset)
          7'd0: rom = 8'h04; 7'd1: rom = 8'h03; 7'd2: rom = 8'h09; 7'd3: rom = 8'h04;
          default: rom = 8'h00;
        endcase
      ucer_pkg::SRC_MANU:
        if (offset == 7'd0) rom = 8'd40;
        else if (offset == 7'd1) rom = 8'h03;
        else if (offset[0] || offset >= 7'd40) rom = 8'h00;
        else rom = ucer_pkg::manu_char(char_idx);
      ucer_pkg::SRC_PROD:
        if (offset == 7'd0) rom = 8'd16;
        else if (offset == 7'd1) rom = 8'h03;
        else if (offset[0] || offset >= 7'd16) rom = 8'h00;
        else rom = ucer_pkg::prod_char(char_idx[2:0]);
      ucer_pkg::SRC_LINE:
        rom = (offset < 7'd7) ? line_coding[offset[2:0]] : 8'h00;
      ucer_pkg::SRC_LUN:
        rom = (offset == 7'd0) ? {4'd0, max_lun} : 8'h00;
      default: rom = 8'h00;
    endcase
  end

  // setup decode
  logic       setup_ok;
  logic [2:0] new_phase, new_src;
  logic [6:0] new_limit;
  logic       new_addr;
  always_comb begin
    setup_ok = 1'b1;
    new_phase = ucer_pkg::PH_IN;
    new_src = ucer_pkg::SRC_NONE;
    new_limit = 7'd0;
    new_addr = 1'b0;
    case (setup_request)
      ucer_pkg::REQ_GET_DESC:
        if (value_high == 8'd1) begin
          new_src = ucer_pkg::SRC_DEV; new_limit = 7'd18;
        end else if (value_high == 8'd2) begin
          new_src = ucer_pkg::SRC_CFG; new_limit = 7'(ucer_pkg::CFG_LEN);
        end else if (value_high == 8'd3 && value_low == 8'd0) begin
          new_src = ucer_pkg::SRC_LANG; new_limit = 7'd4;
        end else if (value_high == 8'd3 && value_low == 8'd1) begin
          new_src = ucer_pkg::SRC_MANU; new_limit = 7'd40;
        end else if (value_high == 8'd3 && value_low == 8'd2) begin
          new_src = ucer_pkg::SRC_PROD; new_limit = 7'd16;
        end else setup_ok = 1'b0;
      ucer_pkg::REQ_SET_ADDRESS: begin
        new_phase = ucer_pkg::PH_ADDR; new_addr = 1'b1;
      end
      ucer_pkg::REQ_SET_CONFIG, ucer_pkg::REQ_LINE_STATE,
      ucer_pkg::REQ_STORAGE_RESET: ;
      ucer_pkg::REQ_SET_LINE: begin
        new_phase = ucer_pkg::PH_OUT; new_src = ucer_pkg::SRC_LINE; new_limit = 7'd7;
      end
      ucer_pkg::REQ_GET_LINE: begin
        new_src = ucer_pkg::SRC_LINE; new_limit = 7'd7;
      end
      ucer_pkg::REQ_GET_MAX_LUN: begin
        new_src = ucer_pkg::SRC_LUN; new_limit = 7'd1;
      end
      default: setup_ok = 1'b0;
    endcase
    if (setup_request == ucer_pkg::REQ_GET_MAX_LUN) new_limit = 7'd1;
    else if (max_length < 16'(new_limit)) new_limit = max_length[6:0];
  end

  wire in_phase = (phase == ucer_pkg::PH_IN) || (phase == ucer_pkg::PH_ADDR);
  wire [6:0] pkt_n = (remaining < PKT) ? remaining : PKT;
  wire hold = out_valid && !out_ready;

  assign stat.busy = busy || cmd.start || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lun <= 4'd0; bulk_pkt_len <= 10'd512; int_ival <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        ucer_pkg::REG_MAX_LUN:   max_lun <= cfg_data[3:0];
        ucer_pkg::REG_BULK_PKT:  bulk_pkt_len <= cfg_data;
        ucer_pkg::REG_INT_IVAL:  int_ival <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ucer_pkg::PH_IDLE; src <= ucer_pkg::SRC_NONE;
      offset <= 7'd0; remaining <= 7'd0;
      addr <= 7'd0; addr_on <= 1'b0; enum_flag <= 1'b0; susp <= 1'b0;
      busy <= 1'b0; burst_left <= 7'd0; out_valid <= 1'b0;
      line_coding[0] <= 8'h00; line_coding[1] <= 8'hC2; line_coding[2] <= 8'h01;
      line_coding[3] <= 8'h00; line_coding[4] <= 8'h00; line_coding[5] <= 8'h00;
      line_coding[6] <= 8'h08;
      kind <= ucer_pkg::KIND_IGNORED; data_byte <= 8'h00; last <= 1'b0;
    end else if (!hold) begin
      out_valid <= 1'b0;
      if (busy) begin
        // one packet byte per cycle while the output is not stalled
        out_valid <= 1'b1;
        kind <= ucer_pkg::KIND_DATA;
        data_byte <= rom;
        last <= (burst_left == 7'd1);
        offset <= offset + 7'd1;
        burst_left <= burst_left - 7'd1;
        if (burst_left == 7'd1) busy <= 1'b0;
      end else if (cmd.start) begin
        out_valid <= 1'b1;
        data_byte <= 8'h00;
        last <= 1'b1;
        kind <= ucer_pkg::KIND_IGNORED;
        case (cmd.op)
          ucer_pkg::OP_BUS_RESET: begin
            phase <= ucer_pkg::PH_IDLE; src <= ucer_pkg::SRC_NONE;
            offset <= 7'd0; remaining <= 7'd0;
            addr <= 7'd0; addr_on <= 1'b0; enum_flag <= 1'b0;
            kind <= ucer_pkg::KIND_STATUS;
          end
          ucer_pkg::OP_WAKEUP: begin
            susp <= 1'b0; kind <= ucer_pkg::KIND_STATUS;
          end
          ucer_pkg::OP_SUSPEND: begin
            susp <= 1'b1; kind <= ucer_pkg::KIND_STATUS;
          end
          ucer_pkg::OP_SETUP:
            if (setup_complete && setup_ok) begin
              phase <= new_phase; src <= new_src;
              offset <= 7'd0; remaining <= new_limit;
              if (new_addr) addr <= value_low[6:0];
              kind <= ucer_pkg::KIND_STATUS;
            end
          ucer_pkg::OP_OUT_BYTE:
            if (phase == ucer_pkg::PH_OUT) begin
              if (remaining != 7'd0 && offset < 7'd7) begin
                line_coding[offset[2:0]] <= out_data;
                offset <= offset + 7'd1;
                remaining <= remaining - 7'd1;
              end else phase <= ucer_pkg::PH_IDLE;
              kind <= ucer_pkg::KIND_STATUS;
            end
          ucer_pkg::OP_IN_TOKEN:
            if (in_phase) begin
              if (phase == ucer_pkg::PH_ADDR) begin
                addr_on <= 1'b1; enum_flag <= 1'b1;
              end
              if (pkt_n == 7'd0) begin
                phase <= ucer_pkg::PH_IDLE;
                kind <= ucer_pkg::KIND_ZLP;
              end else begin
                // bytes follow from the burst counter
                out_valid <= 1'b0;
                busy <= 1'b1;
                burst_left <= pkt_n;
                remaining <= remaining - pkt_n;
              end
            end
          ucer_pkg::OP_OUT_EMPTY:
            if (phase == ucer_pkg::PH_OUT) begin
              phase <= ucer_pkg::PH_IDLE; kind <= ucer_pkg::KIND_STATUS;
            end
          default: ;
        endcase
      end
    end
  end

  assign device_address  = addr;
  assign address_enabled = addr_on;
  assign enumerated      = enum_flag;
  assign tx_armed        = in_phase;
  assign rx_armed        = (phase == ucer_pkg::PH_OUT);
  assign suspended       = susp;

endmodule
`default_nettype wire

// ----- rtl/ucer_checker.sv -----
`default_nettype none
module ucer_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] kind,
  input wire logic       last,
  input wire logic       address_enabled,
  input wire logic       tx_armed,
  input wire logic       rx_armed
);

  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("beat taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(tx_armed && rx_armed)) else $error("tx and rx both armed");

  a_nondata_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != ucer_pkg::KIND_DATA |-> last) else $error("single result not last");

  a_addr_off_reset: assert property (@(posedge clk)
    $past(rst) |-> !address_enabled) else $error("address on after reset");

endmodule

bind usb_control_endpoint_responder ucer_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last),
  .address_enabled(address_enabled), .tx_armed(tx_armed), .rx_armed(rx_armed)
);
`default_nettype wire

// ----- tb/sv/usb_control_endpoint_responder_tb.sv -----
`default_nettype none
module usb_control_endpoint_responder_tb;

  localparam logic [2:0] OP_UNUSED = 3'd7;  // no such bus event
  localparam int EP0_BYTES = 64;
  localparam int STALL_LIMIT = 5000;        // cycles with no beat moving on either side
  localparam int LONG_HOLD = 300;           // receiver hold-off for the pressure test

  // one result beat as the block should present it
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
    logic [6:0] address;
    logic       addr_on;
    logic       enum_done;
    logic       tx;
    logic       rx;
    logic       susp;
  } ep0_beat_t;

  // ---------------------------------------------------------------- dut
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = ucer_pkg::OP_WAKEUP;
  logic [7:0]  setup_request = '0;
  logic [7:0]  value_low = '0;
  logic [7:0]  value_high = '0;
  logic [15:0] max_length = '0;
  logic        setup_complete = 1'b0;
  logic [7:0]  out_data = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = ucer_pkg::REG_MAX_LUN;
  logic [9:0]  cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        last;
  logic [6:0]  device_address;
  logic        address_enabled;
  logic        enumerated;
  logic        tx_armed;
  logic        rx_armed;
  logic        suspended;

  usb_control_endpoint_responder u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- shadow state
  logic [3:0] lun_reg;
  logic [9:0] bulk_len_reg;
  logic [7:0] ival_reg;
  logic [2:0] phase;
  logic [2:0] source;
  logic [6:0] offset;
  logic [6:0] remaining;
  logic [7:0] line_coding [7];
  logic [6:0] addr;
  logic       addr_on;
  logic       enum_done;
  logic       susp;

  ep0_beat_t pending_results[$];
  bit        failed = 0;
  bit        quiet = 0;          // no idling on either side while set
  bit        long_hold_req = 0;  // toggled by a test to ask for a long hold-off
  bit        long_hold_seen = 0;
  int        hold_off = 0;       // receiver holds out_ready low this many cycles
  int        stall_cycles = 0;

  // descriptor rom contents, written out by hand
  localparam logic [7:0] DEV_ROM [18] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'hEF, 8'h02, 8'h01, 8'h00,
    8'h40, 8'h1c, 8'h38, 8'h05, 8'h01, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01};
  localparam logic [7:0] CFG_ROM [106] = '{
    8'h09, 8'h02, 8'h6A, 8'h00, 8'h03, 8'h01, 8'h00, 8'h80, 8'd200,
    8'h08, 8'h0B, 8'h00, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h00, 8'h00,
    8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
    8'h04, 8'h24, 8'h02, 8'h00,
    8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
    8'h05, 8'h24, 8'h01, 8'h00, 8'h01,
    8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'h00,
    8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h06,
    8'h07, 8'h05, 8'h81, 8'h02, 8'h00, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h02, 8'h02, 8'h00, 8'h00, 8'h00,
    8'h08, 8'h0B, 8'h02, 8'h01, 8'h08, 8'h06, 8'h50, 8'h00,
    8'h09, 8'h04, 8'h02, 8'h00, 8'h02, 8'h08, 8'h06, 8'h50, 8'h00,
    8'h07, 8'h05, 8'h84, 8'h02, 8'h00, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h05, 8'h02, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] LANG_ROM [4] = '{8'h04, 8'h03, 8'h09, 8'h04};
  localparam logic [7:0] MANU_TEXT [19] = '{
    8'h4D, 8'h61, 8'h6E, 8'h75, 8'h46, 8'h65, 8'h72, 8'h48, 8'h69, 8'h2F,
    8'h53, 8'h6C, 8'h69, 8'h6E, 8'h67, 8'h73, 8'h68, 8'h6F, 8'h74};
  localparam logic [7:0] PROD_TEXT [7] = '{
    8'h53, 8'h69, 8'h44, 8'h69, 8'h31, 8'h32, 8'h38};

  // utf-16 string descriptor: length, type, then chars with zero high bytes
  function automatic logic [7:0] string_desc_byte(input logic [2:0] src, input int idx);
    int n;
    n = (src == ucer_pkg::SRC_MANU) ? 19 : 7;
    if (idx == 0) return 8'(2 + 2 * n);
    if (idx == 1) return 8'h03;
    if (idx[0]) return 8'h00;
    if ((idx - 2) / 2 < n) return (src == ucer_pkg::SRC_MANU) ? MANU_TEXT[(idx - 2) / 2]
                                                              : PROD_TEXT[(idx - 2) / 2];
    return 8'h00;
  endfunction

  function automatic logic [7:0] descriptor_byte(input logic [2:0] src, input logic [6:0] i);
    int idx;
    idx = int'(i);
    case (src)
      ucer_pkg::SRC_DEV: begin
        if (idx == 7) return 8'(EP0_BYTES);
        return idx < 18 ? DEV_ROM[idx] : 8'h00;
      end
      ucer_pkg::SRC_CFG: begin
        if (idx == 51) return ival_reg;
        // bulk endpoint max packet size, little endian
        if (idx == 65 || idx == 72 || idx == 96 || idx == 103) return bulk_len_reg[7:0];
        if (idx == 66 || idx == 73 || idx == 97 || idx == 104)
          return {6'd0, bulk_len_reg[9:8]};
        return idx < 106 ? CFG_ROM[idx] : 8'h00;
      end
      ucer_pkg::SRC_LANG: return idx < 4 ? LANG_ROM[idx] : 8'h00;
      ucer_pkg::SRC_MANU: return idx < 40 ? string_desc_byte(src, idx) : 8'h00;
      ucer_pkg::SRC_PROD: return idx < 16 ? string_desc_byte(src, idx) : 8'h00;
      ucer_pkg::SRC_LINE: return idx < 7 ? line_coding[idx] : 8'h00;
      ucer_pkg::SRC_LUN:  return idx == 0 ? {4'd0, lun_reg} : 8'h00;
      default:  return 8'h00;
    endcase
  endfunction

  function automatic void start_transfer(input logic [2:0] ph, input logic [2:0] src,
                                         input int len, input int limit);
    phase = ph;
    source = src;
    offset = '0;
    remaining = 7'(len < limit ? len : limit);
  endfunction

  // decode one setup packet, return 1 when the request is taken
  function automatic bit decode_setup(input logic [7:0] req, input logic [7:0] vlo,
                                      input logic [7:0] vhi, input logic [15:0] len);
    case (req)
      ucer_pkg::REQ_GET_DESC: begin
        if (vhi == 8'd1) begin
          start_transfer(ucer_pkg::PH_IN, ucer_pkg::SRC_DEV, len, 18); return 1;
        end
        if (vhi == 8'd2) begin
          start_transfer(ucer_pkg::PH_IN, ucer_pkg::SRC_CFG, len, 106); return 1;
        end
        if (vhi == 8'd3) begin
          if (vlo == 8'd0) begin
            start_transfer(ucer_pkg::PH_IN, ucer_pkg::SRC_LANG, len, 4); return 1;
          end
          if (vlo == 8'd1) begin
            start_transfer(ucer_pkg::PH_IN, ucer_pkg::SRC_MANU, len, 40); return 1;
          end
          if (vlo == 8'd2) begin
            start_transfer(ucer_pkg::PH_IN, ucer_pkg::SRC_PROD, len, 16); return 1;
          end
        end
        return 0;
      end
      ucer_pkg::REQ_SET_ADDRESS: begin
        addr = vlo[6:0];
        start_transfer(ucer_pkg::PH_ADDR, ucer_pkg::SRC_NONE, 0, 0);
        return 1;
      end
      ucer_pkg::REQ_SET_CONFIG, ucer_pkg::REQ_LINE_STATE, ucer_pkg::REQ_STORAGE_RESET: begin
        start_transfer(ucer_pkg::PH_IN, ucer_pkg::SRC_NONE, 0, 0);
        return 1;
      end
      ucer_pkg::REQ_SET_LINE: begin
        start_transfer(ucer_pkg::PH_OUT, ucer_pkg::SRC_LINE, len, 7); return 1;
      end
      ucer_pkg::REQ_GET_LINE: begin
        start_transfer(ucer_pkg::PH_IN, ucer_pkg::SRC_LINE, len, 7); return 1;
      end
      ucer_pkg::REQ_GET_MAX_LUN: begin
        start_transfer(ucer_pkg::PH_IN, ucer_pkg::SRC_LUN, 1, 1); return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic reset_shadow();
    lun_reg = '0;
    bulk_len_reg = 10'd512;
    ival_reg = 8'd1;
    phase = ucer_pkg::PH_IDLE;
    source = ucer_pkg::SRC_NONE;
    offset = '0;
    remaining = '0;
    line_coding = '{8'h00, 8'hC2, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08};
    addr = '0;
    addr_on = 1'b0;
    enum_done = 1'b0;
    susp = 1'b0;
  endtask

  // work out every result beat caused by one accepted input beat
  task automatic predict_ep0_response(input logic [2:0] o, input logic [7:0] req,
                                      input logic [7:0] vlo, input logic [7:0] vhi,
                                      input logic [15:0] len, input logic sc,
                                      input logic [7:0] od);
    logic [7:0] pkt [EP0_BYTES];
    logic [1:0] k;
    int n, cnt;
    ep0_beat_t b;
    k = ucer_pkg::KIND_IGNORED;
    n = 0;
    case (o)
      ucer_pkg::OP_BUS_RESET: begin
        phase = ucer_pkg::PH_IDLE; source = ucer_pkg::SRC_NONE;
        offset = '0; remaining = '0;
        addr = '0; addr_on = 1'b0; enum_done = 1'b0;
        k = ucer_pkg::KIND_STATUS;
      end
      ucer_pkg::OP_WAKEUP:  begin susp = 1'b0; k = ucer_pkg::KIND_STATUS; end
      ucer_pkg::OP_SUSPEND: begin susp = 1'b1; k = ucer_pkg::KIND_STATUS; end
      ucer_pkg::OP_SETUP: if (sc && decode_setup(req, vlo, vhi, len)) k = ucer_pkg::KIND_STATUS;
      ucer_pkg::OP_OUT_BYTE: if (phase == ucer_pkg::PH_OUT) begin
        if (remaining > 0 && offset < 7) begin
          line_coding[offset] = od;
          offset++;
          remaining--;
        end else begin
          phase = ucer_pkg::PH_IDLE;
        end
        k = ucer_pkg::KIND_STATUS;
      end
      ucer_pkg::OP_IN_TOKEN: if (phase == ucer_pkg::PH_IN || phase == ucer_pkg::PH_ADDR) begin
        n = remaining < EP0_BYTES ? int'(remaining) : EP0_BYTES;
        for (int i = 0; i < n; i++) pkt[i] = descriptor_byte(source, 7'(offset + i));
        offset = 7'(offset + n);
        remaining = 7'(remaining - n);
        if (phase == ucer_pkg::PH_ADDR) begin addr_on = 1'b1; enum_done = 1'b1; end
        if (n == 0) begin phase = ucer_pkg::PH_IDLE; k = ucer_pkg::KIND_ZLP; end
        else k = ucer_pkg::KIND_DATA;
      end
      ucer_pkg::OP_OUT_EMPTY: if (phase == ucer_pkg::PH_OUT) begin
        phase = ucer_pkg::PH_IDLE; k = ucer_pkg::KIND_STATUS;
      end
      default: ;
    endcase
    cnt = (k == ucer_pkg::KIND_DATA) ? n : 1;
    for (int i = 0; i < cnt; i++) begin
      b.kind = k;
      b.data_byte = (k == ucer_pkg::KIND_DATA) ? pkt[i] : 8'h00;
      b.last = (i + 1 == cnt);
      b.address = addr;
      b.addr_on = addr_on;
      b.enum_done = enum_done;
      b.tx = (phase == ucer_pkg::PH_IN || phase == ucer_pkg::PH_ADDR);
      b.rx = (phase == ucer_pkg::PH_OUT);
      b.susp = susp;
      pending_results.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------- result side
  // receiver: random stalls, plus a long counted hold-off on request
  always @(negedge clk) begin
    if (long_hold_req != long_hold_seen) begin
      long_hold_seen <= long_hold_req;
      out_ready <= 1'b0;
      hold_off <= LONG_HOLD;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_ready <= 1'b0;
      hold_off <= $urandom_range(5, 40);  // occasional long stall
    end else begin
      out_ready <= $urandom_range(0, 3) != 0;
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, exp_v, act_v);
      failed = 1;
    end
  endtask

  always @(posedge clk) begin
    ep0_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got kind %0d data %0h",
                 $time, kind, data_byte);
        failed = 1;
      end else begin
        e = pending_results.pop_front();
        check_field("kind", e.kind, kind);
        check_field("data_byte", e.data_byte, data_byte);
        check_field("last", e.last, last);
        check_field("device_address", e.address, device_address);
        check_field("address_enabled", e.addr_on, address_enabled);
        check_field("enumerated", e.enum_done, enumerated);
        check_field("tx_armed", e.tx, tx_armed);
        check_field("rx_armed", e.rx, rx_armed);
        check_field("suspended", e.susp, suspended);
      end
    end
  end

  // watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL usb_control_endpoint_responder");
      $finish;
    end
  end

  // ---------------------------------------------------------------- input side
  task automatic idle_gap();
    int g;
    if (quiet) return;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // offer one beat, hold it until taken, then predict its results
  task automatic send_beat(input logic [2:0] o, input logic [7:0] req = 8'h00,
                           input logic [7:0] vlo = 8'h00, input logic [7:0] vhi = 8'h00,
                           input logic [15:0] len = 16'h0000, input logic sc = 1'b1,
                           input logic [7:0] od = 8'h00);
    op = o; setup_request = req; value_low = vlo; value_high = vhi;
    max_length = len; setup_complete = sc; out_data = od;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_ep0_response(o, req, vlo, vhi, len, sc, od);
    @(negedge clk);
    idle_gap();
  endtask

  task automatic setup_beat(input logic [7:0] req, input logic [7:0] vlo,
                            input logic [7:0] vhi, input logic [15:0] len);
    send_beat(ucer_pkg::OP_SETUP, req, vlo, vhi, len, 1'b1, 8'($urandom));
  endtask

  // wait for every expected beat, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    drain();
    cfg_write = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      ucer_pkg::REG_MAX_LUN:   lun_reg = val[3:0];
      ucer_pkg::REG_BULK_PKT:  bulk_len_reg = val;
      ucer_pkg::REG_INT_IVAL:  ival_reg = val[7:0];
      default: ;
    endcase
  endtask

  // IN tokens until the transfer ends with a zero-length packet
  task automatic read_all_in();
    int guard;
    guard = 0;
    while ((phase == ucer_pkg::PH_IN || phase == ucer_pkg::PH_ADDR) && guard < 6) begin
      send_beat(ucer_pkg::OP_IN_TOKEN);
      guard++;
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_descriptors();
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h00, 8'd1, 16'hFFFF);  // device, clipped to 18
    read_all_in();
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h00, 8'd2, 16'd106);   // config, 64 + 42 + zlp
    read_all_in();
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h00, 8'd3, 16'd4);
    read_all_in();
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h01, 8'd3, 16'd255);
    read_all_in();
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h02, 8'd3, 16'd3);     // product, short read
    read_all_in();
  endtask

  task automatic test_rejects();
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h00, 8'd1, 16'd9);
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h03, 8'd3, 16'd9);     // bad string index
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h00, 8'd4, 16'd9);     // bad descriptor type
    setup_beat(8'h00, 8'h00, 8'h00, 16'd0);                     // unknown request
    send_beat(ucer_pkg::OP_SETUP, ucer_pkg::REQ_SET_CONFIG, 8'h01, 8'h00, 16'd0,
              1'b0);                                            // short setup
    read_all_in();
    send_beat(ucer_pkg::OP_IN_TOKEN);                           // stray IN
    send_beat(ucer_pkg::OP_OUT_BYTE, .od(8'hA5));               // stray OUT
    send_beat(ucer_pkg::OP_OUT_EMPTY);
    send_beat(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 8'hFF);
  endtask

  task automatic test_enumeration();
    setup_beat(ucer_pkg::REQ_SET_ADDRESS, 8'hFF, 8'h00, 16'd0); // address wraps to 7 bits
    send_beat(ucer_pkg::OP_IN_TOKEN);                           // status stage turns it on
    setup_beat(ucer_pkg::REQ_SET_ADDRESS, 8'h05, 8'h00, 16'd0); // replaced, not ored
    read_all_in();
    setup_beat(ucer_pkg::REQ_SET_CONFIG, 8'h01, 8'h00, 16'd0);
    read_all_in();
    send_beat(ucer_pkg::OP_SUSPEND);
    setup_beat(ucer_pkg::REQ_LINE_STATE, 8'h03, 8'h00, 16'd0);  // handled while suspended
    read_all_in();
    send_beat(ucer_pkg::OP_WAKEUP);
    send_beat(ucer_pkg::OP_BUS_RESET);                          // clears the address
  endtask

  task automatic test_class_requests();
    setup_beat(ucer_pkg::REQ_SET_LINE, 8'h00, 8'h00, 16'd7);
    for (int i = 0; i < 7; i++) send_beat(ucer_pkg::OP_OUT_BYTE, .od(8'(8'h11 * (i + 1))));
    send_beat(ucer_pkg::OP_OUT_BYTE, .od(8'h99));               // no bytes left, phase ends
    setup_beat(ucer_pkg::REQ_GET_LINE, 8'h00, 8'h00, 16'hFFFF);
    read_all_in();
    setup_beat(ucer_pkg::REQ_SET_LINE, 8'h00, 8'h00, 16'd3);
    send_beat(ucer_pkg::OP_OUT_BYTE, .od(8'h00));
    send_beat(ucer_pkg::OP_OUT_EMPTY);                          // early end of data stage
    setup_beat(ucer_pkg::REQ_STORAGE_RESET, 8'h00, 8'h00, 16'd0);
    read_all_in();
    setup_beat(ucer_pkg::REQ_GET_MAX_LUN, 8'h00, 8'h00, 16'd0); // one byte whatever wLength
    read_all_in();
  endtask

  task automatic test_registers(input logic [3:0] lun, input logic [9:0] bulk,
                                input logic [7:0] ival);
    write_reg(ucer_pkg::REG_MAX_LUN, {6'd0, lun});
    write_reg(ucer_pkg::REG_BULK_PKT, bulk);
    write_reg(ucer_pkg::REG_INT_IVAL, {2'd0, ival});
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h00, 8'd2, 16'hFFFF);
    read_all_in();
    setup_beat(ucer_pkg::REQ_GET_MAX_LUN, 8'h00, 8'h00, 16'd8);
    read_all_in();
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    drain();
    long_hold_req = !long_hold_req;
    setup_beat(ucer_pkg::REQ_GET_DESC, 8'h00, 8'd2, 16'd106);
    send_beat(ucer_pkg::OP_IN_TOKEN);
    send_beat(ucer_pkg::OP_IN_TOKEN);
    send_beat(ucer_pkg::OP_SUSPEND);
    send_beat(ucer_pkg::OP_WAKEUP);
    drain();                                          // sender waits for every result
  endtask

  function automatic logic [7:0] pick_request();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: return ucer_pkg::REQ_GET_DESC;
      4: return ucer_pkg::REQ_SET_ADDRESS;
      5: return ucer_pkg::REQ_SET_CONFIG;
      6: return ucer_pkg::REQ_SET_LINE;
      7: return ucer_pkg::REQ_GET_LINE;
      8: return ucer_pkg::REQ_LINE_STATE;
      9: return ucer_pkg::REQ_STORAGE_RESET;
      10: return ucer_pkg::REQ_GET_MAX_LUN;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic noise_beat();
    send_beat(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // mostly well-formed control transfers with random content
  task automatic test_random(input int n_items);
    int sent;
    logic [7:0] req;
    logic [15:0] len;
    sent = 0;
    while (sent < n_items) begin
      quiet = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 4) == 0) begin
        noise_beat();
        sent++;
      end else begin
        req = pick_request();
        len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 130));
        send_beat(ucer_pkg::OP_SETUP, req,
                  8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                  8'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 3)),
                  len, ($urandom_range(0, 15) != 0), 8'($urandom));
        sent++;
        if (phase == ucer_pkg::PH_OUT) begin
          repeat ($urandom_range(0, 9)) begin
            send_beat(ucer_pkg::OP_OUT_BYTE, .od(8'($urandom)));
            sent++;
          end
          if ($urandom_range(0, 1)) begin send_beat(ucer_pkg::OP_OUT_EMPTY); sent++; end
        end
        while ((phase == ucer_pkg::PH_IN || phase == ucer_pkg::PH_ADDR) &&
               $urandom_range(0, 7) != 0) begin
          send_beat(ucer_pkg::OP_IN_TOKEN);
          sent++;
        end
      end
    end
    quiet = 0;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    int wait_cycles;
    reset_shadow();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_descriptors();
    test_rejects();
    test_enumeration();
    test_class_requests();
    test_backpressure();
    test_registers(4'd15, 10'd8, 8'd255);
    test_random(65);
    test_registers(4'd0, 10'h3FF, 8'd1);
    test_random(65);
    test_registers(4'd7, 10'd64, 8'd10);
    test_random(65);

    in_valid = 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("PASS usb_control_endpoint_responder");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, pending_results.size());
      $display("FAIL usb_control_endpoint_responder");
    end
    $finish;
  end

endmodule
`default_nettype wire
